// ===== sv/dmsrc_pkg.sv =====
// Shared types and constants for the direct-mapped search result cache.
package dmsrc_pkg;

  // Default slot index width (slot count is a power of two of it)
  localparam int unsigned IndexBitsDef = 12;

  // Evaluation returned by a probe that misses
  localparam logic signed [15:0] MissEval = 16'sd10000;

  // Generation value after reset and after clear all
  localparam logic [15:0] GenReset = 16'd1;

  // Action codes of a request
  typedef enum logic [2:0] {
    ACT_PROBE     = 3'd0,
    ACT_STORE     = 3'd1,
    ACT_READ      = 3'd2,
    ACT_WRITE     = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_CLEAR_ALL = 3'd5
  } action_e;

  // One table slot as held in memory
  typedef struct packed {
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [15:0]        gen;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // One captured request
  typedef struct packed {
    logic [2:0]         action;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [15:0]        egen;
  } req_t;

  // One result
  typedef struct packed {
    logic               hit;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [15:0]        gen;
    logic               done;
  } result_t;

  // Slot write-back decided from a request and the slot read
  typedef struct packed {
    logic   we;
    entry_t data;
  } wback_t;

endpackage

// ===== sv/dmsrc_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module dmsrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dmsrc_decide.sv =====
// Hit and replacement decision, write-back data and result formatting.
module dmsrc_decide (
  input  dmsrc_pkg::req_t    req_i,
  input  dmsrc_pkg::entry_t  slot_i,
  input  logic [15:0]        generation_i,
  output dmsrc_pkg::wback_t  wb_o,
  output dmsrc_pkg::result_t res_o
);

  logic key_eq;
  logic probe_hit;
  logic replace;
  dmsrc_pkg::entry_t new_entry;

  // Compares against the stored slot
  assign key_eq    = (slot_i.key == req_i.key);
  assign probe_hit = key_eq && ($signed(slot_i.depth) >= $signed(req_i.depth));
  assign replace   = key_eq || ($signed(req_i.depth) >= $signed(slot_i.depth)) ||
                     (generation_i > slot_i.gen);

  // Entry built from the request; stamp chosen per action
  always_comb begin
    new_entry.key   = req_i.key;
    new_entry.depth = req_i.depth;
    new_entry.score = req_i.score;
    new_entry.move  = req_i.move;
    new_entry.gen   = generation_i;
    if (req_i.action == dmsrc_pkg::ACT_WRITE) begin
      new_entry.gen = req_i.egen;
    end
  end

  // Per-action write-back and result
  always_comb begin
    wb_o  = '0;
    res_o = '0;
    unique case (req_i.action)
      dmsrc_pkg::ACT_PROBE: begin
        res_o.done = 1'b1;
        if (probe_hit) begin
          res_o.hit   = 1'b1;
          res_o.depth = slot_i.depth;
          res_o.score = slot_i.score;
          res_o.move  = slot_i.move;
        end else begin
          res_o.score = dmsrc_pkg::MissEval;
        end
      end
      dmsrc_pkg::ACT_STORE: begin
        res_o.done = 1'b1;
        wb_o.we    = replace;
        wb_o.data  = new_entry;
      end
      dmsrc_pkg::ACT_READ: begin
        res_o.done  = 1'b1;
        res_o.key   = slot_i.key;
        res_o.depth = slot_i.depth;
        res_o.score = slot_i.score;
        res_o.move  = slot_i.move;
        res_o.gen   = slot_i.gen;
      end
      dmsrc_pkg::ACT_WRITE: begin
        res_o.done = 1'b1;
        wb_o.we    = 1'b1;
        wb_o.data  = new_entry;
      end
      dmsrc_pkg::ACT_CLEAR: begin
        res_o.done = 1'b1;
        wb_o.we    = 1'b1;
      end
      dmsrc_pkg::ACT_CLEAR_ALL: begin
        // sweep already done by the controller
        res_o.done = 1'b1;
      end
      default: begin
        // unused codes: no change, empty result
      end
    endcase
  end

endmodule

// ===== sv/direct_mapped_search_result_cache.sv =====
// Direct-mapped search result cache: one slot per key index, depth-preferred replacement.
//
// Requests arrive on the in_* channel (valid/ready) with an action, a 64-bit key
// and entry fields; the low INDEX_BITS of the key select the slot. Each request
// gives exactly one result on the out_* channel (valid/ready), held in an output
// register. The generation register is written over the cfg_* channel, always ready.
// Probe, store, read, write and clear of one slot first read the slot memory into
// its registered read port, then decide, write back and load the result register;
// that last step waits while the output register is still full. A new request is
// taken only once the previous one completes, since the single memory port serves
// the read and then the write-back. Clear all walks every slot, one per cycle, then
// gives its result, and it sets the generation back to 1.
// After reset the same sweep runs over all SLOT_COUNT slots (4096 by default) with
// in_ready_o low; configuration writes are taken during it.
// If the receiver stalls with a result waiting, the next request is still taken
// and read, then holds until the output register frees.
module direct_mapped_search_result_cache #(
  parameter int unsigned INDEX_BITS = dmsrc_pkg::IndexBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  // requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [63:0]        key_i,
  input  logic signed [7:0]  depth_i,
  input  logic signed [15:0] eval_in_i,
  input  logic [15:0]        move_in_i,
  input  logic [15:0]        entry_generation_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [63:0]        key_out_o,
  output logic signed [7:0]  stored_depth_o,
  output logic signed [15:0] eval_out_o,
  output logic [15:0]        move_out_o,
  output logic [15:0]        generation_out_o,
  output logic               done_res_o
);

  localparam int unsigned SlotCount = 1 << INDEX_BITS;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e                  state_q, state_d;
  logic [INDEX_BITS-1:0]   sweep_q, sweep_d;
  logic                    reply_q, reply_d;
  logic [15:0]             gen_q, gen_d;
  logic                    out_valid_q, out_valid_d;
  dmsrc_pkg::result_t      res_q, res_d;
  dmsrc_pkg::req_t         req_q, req_d;

  logic                    in_acc;
  logic                    complete;
  logic                    mem_we;
  logic                    mem_re;
  logic [INDEX_BITS-1:0]   mem_addr;
  dmsrc_pkg::entry_t       mem_wdata;
  logic [dmsrc_pkg::EntryW-1:0] mem_rdata;
  dmsrc_pkg::wback_t       wb;
  dmsrc_pkg::result_t      res;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign complete    = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);

  // Slot memory
  dmsrc_ram #(
    .WIDTH (dmsrc_pkg::EntryW),
    .DEPTH (SlotCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Decision on the slot just read
  dmsrc_decide u_decide (
    .req_i        (req_q),
    .slot_i       (dmsrc_pkg::entry_t'(mem_rdata)),
    .generation_i (gen_q),
    .wb_o         (wb),
    .res_o        (res)
  );

  // Memory port: read on accept, write back on completion, zero during sweep
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = req_q.key[INDEX_BITS-1:0];
    mem_wdata = wb.data;
    unique case (state_q)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re   = in_acc;
        mem_addr = key_i[INDEX_BITS-1:0];
      end
      ST_LOOK: begin
        mem_we = complete && wb.we;
      end
      default: begin
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    reply_d     = reply_q;
    gen_d       = gen_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_valid_i) begin
      gen_d = cfg_data_i;
    end

    unique case (state_q)
      ST_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == INDEX_BITS'(SlotCount - 1)) begin
          state_d = reply_q ? ST_LOOK : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_d.action = action_i;
          req_d.key    = key_i;
          req_d.depth  = depth_i;
          req_d.score  = eval_in_i;
          req_d.move   = move_in_i;
          req_d.egen   = entry_generation_i;
          if (action_i == dmsrc_pkg::ACT_CLEAR_ALL) begin
            state_d = ST_SWEEP;
            sweep_d = '0;
            reply_d = 1'b1;
            gen_d   = dmsrc_pkg::GenReset;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (complete) begin
          res_d       = res;
          out_valid_d = 1'b1;
          reply_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      reply_q     <= 1'b0;
      gen_q       <= dmsrc_pkg::GenReset;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      reply_q     <= reply_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  // Captured request
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = res_q.hit;
  assign key_out_o        = res_q.key;
  assign stored_depth_o   = res_q.depth;
  assign eval_out_o       = res_q.score;
  assign move_out_o       = res_q.move;
  assign generation_out_o = res_q.gen;
  assign done_res_o       = res_q.done;

  // One request in flight: an accepted request blocks the next one from the following cycle on
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Memory writes only during write-back or sweep
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_LOOK || state_q == ST_SWEEP))
    else $error("slot memory written outside write-back or sweep");

  // A result without done is an empty result
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (!hit_o && eval_out_o == 16'sd0 && key_out_o == 64'd0))
    else $error("unused action produced a non-empty result");

  // Completing a request always presents a result next cycle
  a_complete_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete |=> out_valid_o)
    else $error("completed request did not present a result");

endmodule

// ===== bench/direct_mapped_search_result_cache_tb.sv =====
// Testbench for the direct-mapped search result cache, checked against a slot mirror.
`timescale 1ns / 1ps

module direct_mapped_search_result_cache_tb;

  localparam int unsigned IndexBits     = dmsrc_pkg::IndexBitsDef;
  localparam int unsigned SlotCount     = 1 << IndexBits;
  // action codes the block does not define
  localparam logic [2:0]  ActSpare6     = 3'd6;
  localparam logic [2:0]  ActSpare7     = 3'd7;
  localparam int unsigned MaxPrinted    = 60;
  localparam int unsigned HoldOffCycles = 300;

  localparam logic [63:0] KeyHigh  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KeyAlias = 64'h0123_4567_89AB_CFFF;
  localparam logic [63:0] KeyLow   = 64'h5555_5555_5555_5000;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               cfg_valid_i        = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i         = '0;
  logic               in_valid_i         = 1'b0;
  logic               in_ready_o;
  logic [2:0]         action_i           = '0;
  logic [63:0]        key_i              = '0;
  logic signed [7:0]  depth_i            = '0;
  logic signed [15:0] eval_in_i          = '0;
  logic [15:0]        move_in_i          = '0;
  logic [15:0]        entry_generation_i = '0;
  logic               out_valid_o;
  logic               out_ready_i        = 1'b0;
  logic               hit_o;
  logic [63:0]        key_out_o;
  logic signed [7:0]  stored_depth_o;
  logic signed [15:0] eval_out_o;
  logic [15:0]        move_out_o;
  logic [15:0]        generation_out_o;
  logic               done_res_o;

  direct_mapped_search_result_cache dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .key_i              (key_i),
    .depth_i            (depth_i),
    .eval_in_i          (eval_in_i),
    .move_in_i          (move_in_i),
    .entry_generation_i (entry_generation_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .hit_o              (hit_o),
    .key_out_o          (key_out_o),
    .stored_depth_o     (stored_depth_o),
    .eval_out_o         (eval_out_o),
    .move_out_o         (move_out_o),
    .generation_out_o   (generation_out_o),
    .done_res_o         (done_res_o)
  );

  // Mirror of the slot memory and the generation register
  dmsrc_pkg::entry_t  slot_mirror [SlotCount];
  logic [15:0]        gen_mirror;
  dmsrc_pkg::result_t pending_results [$];

  int unsigned error_count   = 0;
  bit          gaps_on       = 1'b1;
  int unsigned hold_off_left = 0;
  int unsigned sweep_odds    = 0;   // clear-all chance per thousand requests

  // Small pools of slots and key tags so that keys collide and hit
  logic [IndexBits-1:0] slot_pool [8];
  logic [63-IndexBits:0] tag_pool [4];
  logic [63:0]           last_key = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void wipe_mirror();
    foreach (slot_mirror[i]) slot_mirror[i] = '0;
  endfunction

  // Expected result of one request; updates the mirror
  function automatic dmsrc_pkg::result_t apply_request(dmsrc_pkg::req_t r);
    dmsrc_pkg::result_t   res;
    dmsrc_pkg::entry_t    e;
    logic [IndexBits-1:0] s;
    res      = '0;
    s        = r.key[IndexBits-1:0];
    e        = slot_mirror[s];
    res.done = 1'b1;
    case (r.action)
      dmsrc_pkg::ACT_PROBE: begin
        if (e.key == r.key && $signed(e.depth) >= $signed(r.depth)) begin
          res.hit   = 1'b1;
          res.depth = e.depth;
          res.score = e.score;
          res.move  = e.move;
        end else begin
          res.score = dmsrc_pkg::MissEval;
        end
      end
      dmsrc_pkg::ACT_STORE, dmsrc_pkg::ACT_WRITE: begin
        // write slot always lands; store only on key match, deeper or equally deep entry or newer generation
        if (r.action == dmsrc_pkg::ACT_WRITE || e.key == r.key ||
            $signed(r.depth) >= $signed(e.depth) || gen_mirror > e.gen) begin
          e.key   = r.key;
          e.depth = r.depth;
          e.score = r.score;
          e.move  = r.move;
          e.gen   = (r.action == dmsrc_pkg::ACT_WRITE) ? r.egen : gen_mirror;
          slot_mirror[s] = e;
        end
      end
      dmsrc_pkg::ACT_READ: begin
        res.key   = e.key;
        res.depth = e.depth;
        res.score = e.score;
        res.move  = e.move;
        res.gen   = e.gen;
      end
      dmsrc_pkg::ACT_CLEAR: slot_mirror[s] = '0;
      dmsrc_pkg::ACT_CLEAR_ALL: begin
        wipe_mirror();
        gen_mirror = dmsrc_pkg::GenReset;
      end
      default: res.done = 1'b0;   // undefined codes: no effect, empty result
    endcase
    return res;
  endfunction

  function automatic dmsrc_pkg::req_t build_request(logic [2:0] action, logic [63:0] key,
                                                    logic signed [7:0] depth,
                                                    logic signed [15:0] score,
                                                    logic [15:0] move, logic [15:0] egen);
    dmsrc_pkg::req_t r;
    r.action = action;
    r.key    = key;
    r.depth  = depth;
    r.score  = score;
    r.move   = move;
    r.egen   = egen;
    return r;
  endfunction

  function automatic dmsrc_pkg::req_t random_request();
    dmsrc_pkg::req_t r;
    int unsigned     pick;
    pick = $urandom_range(999);
    if (pick < sweep_odds)  r.action = dmsrc_pkg::ACT_CLEAR_ALL;
    else if (pick < 10)     r.action = pick[0] ? ActSpare6 : ActSpare7;
    else if (pick < 360)    r.action = dmsrc_pkg::ACT_PROBE;
    else if (pick < 660)    r.action = dmsrc_pkg::ACT_STORE;
    else if (pick < 820)    r.action = dmsrc_pkg::ACT_READ;
    else if (pick < 940)    r.action = dmsrc_pkg::ACT_WRITE;
    else                    r.action = dmsrc_pkg::ACT_CLEAR;
    // mostly reuse or collide, sometimes a fully random key
    case ($urandom_range(9))
      0, 1, 2: r.key = last_key;
      3:       r.key = {$urandom, $urandom};
      default: r.key = {tag_pool[$urandom_range(3)], slot_pool[$urandom_range(7)]};
    endcase
    last_key = r.key;
    case ($urandom_range(7))
      0:       r.depth = 8'sh80;
      1:       r.depth = 8'sh7F;
      default: r.depth = 8'($urandom);
    endcase
    r.score = 16'($urandom);
    r.move  = 16'($urandom);
    r.egen  = $urandom_range(1) ? 16'($urandom) : 16'(gen_mirror + $urandom_range(2) - 1);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Offer one request and hold it until taken; valid stays high for back-to-back requests
  task automatic send_request(input dmsrc_pkg::req_t r);
    if (gaps_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    action_i           <= r.action;
    key_i              <= r.key;
    depth_i            <= r.depth;
    eval_in_i          <= r.score;
    move_in_i          <= r.move;
    entry_generation_i <= r.egen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_request(r));
  endtask

  // Stop offering and wait until every expected result is back
  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_generation(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gen_mirror = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // Empty table, extremes, replacement rules, spare codes, single and full clear
  task automatic test_directed_cases();
    send_request(build_request(dmsrc_pkg::ACT_PROBE, 64'd0, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_PROBE, 64'd0, 8'sh01, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyHigh, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_WRITE, KeyHigh, 8'sh7F, 16'sh7FFF, 16'hFFFF,
                               16'hFFFF));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyHigh, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_PROBE, KeyHigh, 8'sh7F, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_PROBE, KeyHigh, 8'sh80, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_PROBE, KeyAlias, 8'sh80, 16'sh0000, 16'h0000,
                               16'h0000));
    // other key, shallower, older generation: slot kept
    send_request(build_request(dmsrc_pkg::ACT_STORE, KeyAlias, 8'sh80, 16'sh1111, 16'h2222,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyAlias, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    // same key replaces even when shallower
    send_request(build_request(dmsrc_pkg::ACT_STORE, KeyHigh, 8'sh80, 16'sh8000, 16'h1234,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyHigh, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_PROBE, KeyHigh, 8'sh80, 16'sh0000, 16'h0000,
                               16'h0000));
    // equal depth replaces a different key
    send_request(build_request(dmsrc_pkg::ACT_STORE, KeyAlias, 8'sh80, 16'sh0ABC, 16'h0DEF,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_WRITE, KeyAlias, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    // shallower other key wins on newer generation only
    send_request(build_request(dmsrc_pkg::ACT_STORE, KeyHigh, 8'shFF, 16'sh7FFF, 16'hAAAA,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyHigh, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_CLEAR, KeyHigh, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyAlias, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(ActSpare6, KeyLow, 8'sh7F, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
    send_request(build_request(ActSpare7, KeyLow, 8'sh80, 16'sh8000, 16'h0000, 16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_WRITE, KeyLow, 8'sh55, 16'sh5555, 16'h5555,
                               16'h5555));
    send_request(build_request(dmsrc_pkg::ACT_CLEAR_ALL, KeyLow, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_READ, KeyLow, 8'sh00, 16'sh0000, 16'h0000,
                               16'h0000));
    send_request(build_request(dmsrc_pkg::ACT_PROBE, KeyLow, 8'sh80, 16'sh0000, 16'h0000,
                               16'h0000));
  endtask

  // Traffic under several generation settings, the extremes among them
  task automatic test_generation_settings();
    logic [15:0] setting [4];
    setting[0] = 16'h0000;
    setting[1] = 16'hFFFF;
    setting[2] = 16'($urandom_range(65534, 2));
    setting[3] = dmsrc_pkg::GenReset;
    foreach (setting[i]) begin
      wait_drained(4);
      write_generation(setting[i]);
      run_random(150);
    end
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_result_backpressure();
    wait_drained(4);
    hold_off_left = HoldOffCycles;
    run_random(24);
    wait_drained(4);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    run_random(200);
    gaps_on = 1'b1;
  endtask

  task automatic test_mixed_traffic();
    sweep_odds = 4;
    run_random(600);
    sweep_odds = 0;
  endtask

  // Result receiver: random stalls, or a counted hold-off when one is asked for
  initial begin : result_ready
    forever begin
      @(posedge clk_i);
      if (hold_off_left != 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(99) < 33);
      end
    end
  end

  // Compare each result taken with the oldest expectation
  always @(posedge clk_i) begin : result_check
    dmsrc_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 64'(hit_o), 64'(want.hit));
        check_field("key_out", key_out_o, want.key);
        check_field("stored_depth", 64'(stored_depth_o), 64'(want.depth));
        check_field("eval_out", 64'(eval_out_o), 64'(want.score));
        check_field("move_out", 64'(move_out_o), 64'(want.move));
        check_field("generation_out", 64'(generation_out_o), 64'(want.gen));
        check_field("done_res", 64'(done_res_o), 64'(want.done));
      end
    end
  end

  initial begin : stimulus
    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (int i = 2; i < 8; i++) slot_pool[i] = IndexBits'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 4; i++) tag_pool[i] = (64 - IndexBits)'({$urandom, $urandom});
    wipe_mirror();
    gen_mirror = dmsrc_pkg::GenReset;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // let the power-up sweep finish
    while (!in_ready_o) @(posedge clk_i);

    test_directed_cases();
    test_generation_settings();
    test_result_backpressure();
    test_back_to_back();
    test_mixed_traffic();
    wait_drained(8);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
